/* rtl/fta_pkg.sv */
// Package for the truncating single-precision adder: payload structs,
// stage-to-stage structs and the leading-zero count helper. No dependencies.
package fta_pkg;

  typedef struct packed {
    logic [31:0] addend_a;
    logic [31:0] addend_b;
  } fta_in_t;

  typedef struct packed {
    logic [31:0] sum_bits;
    logic        exponent_overflow;
  } fta_out_t;

  // After alignment: exponent, signs and the two aligned magnitudes.
  typedef struct packed {
    logic        sign_a;
    logic        sign_b;
    logic [7:0]  exp;
    logic [23:0] mant_a;
    logic [23:0] mant_b;
  } fta_align_t;

  // After the signed add: sign and magnitude of the sum.
  typedef struct packed {
    logic        sign;
    logic [7:0]  exp;
    logic [24:0] mag;
  } fta_add_t;

  // Leading zeros of a 24-bit word (24 when it is zero).
  function automatic logic [4:0] fta_lzc(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/float32_truncating_adder.sv */
// Top level of the truncating single-precision adder: three-stage pipeline
// with valid/ready handshakes. Depends on fta_pkg, fta_align, fta_addsub, fta_norm.
//
// One operand pair is taken per transaction on the input channel
// (in_valid_i / in_ready_o / in_data_i) and one result per transaction leaves
// on the output channel (out_valid_o / out_ready_i / out_data_o).
// The pipeline has three register stages: alignment and shift, signed add,
// then normalisation with a leading-zero count and shifter. A new pair can be
// accepted in every cycle while the receiver does not stall, so throughput
// is one transaction per cycle.
// When the receiver stalls, each stage holds its contents; a stage only
// takes new data when it is empty or its content moves on, so bubbles fill
// up first and then in_ready_o falls. Nothing is lost or repeated.
// Reset clears all stage valid bits; the datapath registers are not reset.
// Rounding is truncation; denormals, infinities and NaNs are treated as
// ordinary normal numbers, and an exponent carry past 255 wraps and raises
// exponent_overflow.
module float32_truncating_adder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fta_pkg::fta_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fta_pkg::fta_out_t out_data_o
);
  import fta_pkg::*;

  fta_align_t al_d, al_q;
  fta_add_t   ad_d, ad_q;
  fta_out_t   nm_d, nm_q;
  logic       v1_q, v2_q, v3_q;
  logic       en1, en2, en3;

  fta_align  u_align  (.in_i(in_data_i), .out_o(al_d));
  fta_addsub u_addsub (.in_i(al_q), .out_o(ad_d));
  fta_norm   u_norm   (.in_i(ad_q), .out_o(nm_d));

  // Each stage advances when it is empty or the stage after it moves.
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) al_q <= al_d;
    if (en2) ad_q <= ad_d;
    if (en3) nm_q <= nm_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = nm_q;
endmodule

/* rtl/fta_align.sv */
// Stage one: operand swap and right shift of the smaller mantissa.
// Depends on fta_pkg.
module fta_align (
  input  fta_pkg::fta_in_t    in_i,
  output fta_pkg::fta_align_t out_o
);
  import fta_pkg::*;

  logic [31:0] big, sml;
  logic [7:0]  diff;

  always_comb begin
    if (in_i.addend_a[30:23] < in_i.addend_b[30:23]) begin
      big = in_i.addend_b;
      sml = in_i.addend_a;
    end else begin
      big = in_i.addend_a;
      sml = in_i.addend_b;
    end
    diff         = big[30:23] - sml[30:23];
    out_o.sign_a = big[31];
    out_o.sign_b = sml[31];
    out_o.exp    = big[30:23];
    out_o.mant_a = {1'b1, big[22:0]};
    out_o.mant_b = (diff >= 8'd25) ? '0 : ({1'b1, sml[22:0]} >> diff[4:0]);
  end
endmodule

/* rtl/fta_addsub.sv */
// Stage two: signed addition of the aligned magnitudes, sign and magnitude out.
// Depends on fta_pkg.
module fta_addsub (
  input  fta_pkg::fta_align_t in_i,
  output fta_pkg::fta_add_t   out_o
);
  import fta_pkg::*;

  logic signed [25:0] va, vb, s;

  always_comb begin
    va = in_i.sign_a ? -$signed({2'b00, in_i.mant_a}) : $signed({2'b00, in_i.mant_a});
    vb = in_i.sign_b ? -$signed({2'b00, in_i.mant_b}) : $signed({2'b00, in_i.mant_b});
    s  = va + vb;
    out_o.exp  = in_i.exp;
    out_o.sign = s[25];
    out_o.mag  = s[25] ? 25'(-s) : s[24:0];
  end
endmodule

/* rtl/fta_norm.sv */
// Stage three: carry handling, leading-zero normalisation and packing.
// Depends on fta_pkg.
module fta_norm (
  input  fta_pkg::fta_add_t in_i,
  output fta_pkg::fta_out_t out_o
);
  import fta_pkg::*;

  logic [4:0]  lz;
  logic [8:0]  exp;
  logic [23:0] mag;

  always_comb begin
    lz = fta_lzc(in_i.mag[23:0]);
    if (in_i.mag[24]) begin
      exp = {1'b0, in_i.exp} + 9'd1;
      mag = in_i.mag[24:1];
    end else if ((lz != 5'd24) && ({3'b000, lz} < in_i.exp)) begin
      // A zero magnitude never finds its leading one, so it drains to exponent zero.
      exp = {1'b0, in_i.exp} - {4'b0000, lz};
      mag = in_i.mag[23:0] << lz;
    end else begin
      exp = '0;
      mag = '0;
    end
    out_o.sum_bits          = {in_i.sign, exp[7:0], mag[22:0]};
    out_o.exponent_overflow = exp[8];
  end
endmodule

/* dv/tb_top.sv */
// Testbench for float32_truncating_adder: random and directed operand pairs,
// a bit-exact sum predictor and an in-order scoreboard. Depends on fta_pkg.
module tb_top;
  import fta_pkg::*;

  // Predicts the truncated sum of two single-precision patterns.
  function automatic fta_out_t predict_sum(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a, b, t;
    logic [8:0]  ea, eb, ex, diff;
    logic [23:0] ma, mb;
    logic signed [26:0] sum;
    logic [24:0] mag;
    logic        sgn;
    fta_out_t    r;
    a = a_in;
    b = b_in;
    if (a[30:23] < b[30:23]) begin
      t = a; a = b; b = t;
    end
    ea   = {1'b0, a[30:23]};
    eb   = {1'b0, b[30:23]};
    diff = ea - eb;
    ma   = {1'b1, a[22:0]};
    mb   = {1'b1, b[22:0]};
    mb   = (diff >= 9'd25) ? 24'd0 : (mb >> diff);
    sum  = (a[31] ? -$signed({3'b0, ma}) : $signed({3'b0, ma}))
         + (b[31] ? -$signed({3'b0, mb}) : $signed({3'b0, mb}));
    sgn  = sum < 0;
    mag  = sgn ? 25'(-sum) : 25'(sum);
    if (mag[24]) begin
      ex  = ea + 9'd1;
      mag = mag >> 1;
    end else begin
      ex = ea;
      while (ex > 0 && !mag[23]) begin
        ex  = ex - 9'd1;
        mag = mag << 1;
      end
      if (ex == 0) mag = '0;
    end
    r.sum_bits          = {sgn, ex[7:0], mag[22:0]};
    r.exponent_overflow = ex[8];
    return r;
  endfunction

  // Holds the sums still owed by the block, oldest first.
  class sum_scoreboard;
    fta_out_t pending_sums[$];
    int unsigned mismatches;
    int unsigned checked;

    function void note_operands(fta_in_t op);
      pending_sums.push_back(predict_sum(op.addend_a, op.addend_b));
    endfunction

    function void check_sum(fta_out_t got);
      fta_out_t want;
      checked++;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      want = pending_sums.pop_front();
      if (got.sum_bits !== want.sum_bits ||
          got.exponent_overflow !== want.exponent_overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: sum exp %h ovf %b, got %h ovf %b", want.sum_bits,
                   want.exponent_overflow, got.sum_bits, got.exponent_overflow);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  fta_in_t   in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  fta_out_t  out_data_o;
  sum_scoreboard sb;
  bit        stim_done;

  float32_truncating_adder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sends one operand pair and waits for its transaction to complete. Valid is
  // raised at a falling edge and stays up, unchanged, until accepted.
  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    in_data_i  <= '{addend_a: a, addend_b: b};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operands('{addend_a: a, addend_b: b});
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Builds a pattern from sign, exponent and mantissa fields.
  function automatic logic [31:0] fp(input logic s, input logic [7:0] e,
                                     input logic [22:0] m);
    return {s, e, m};
  endfunction

  // A random operand near another in exponent, so that cancellation and
  // long normalisation shifts are common.
  function automatic logic [31:0] near_operand(input logic [31:0] x);
    logic [7:0] e;
    e = x[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
    return fp(1'($urandom), e, ($urandom_range(0, 1) ? x[22:0] ^ 23'($urandom_range(0, 255))
                                                      : 23'($urandom)));
  endfunction

  // The receiver stalls at random: each cycle it draws its readiness anew,
  // and it is always ready once the stimulus is done.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (($urandom_range(0, 63) < 16) || stim_done) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Results are sampled at the rising edge on which the transaction completes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_sum(out_data_o);
  end

  initial begin
    logic [31:0] a, b;
    int          burst;
    sb         = new();
    stim_done  = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: field extremes and each special case of the datapath.
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h3F80_0000, 32'hBF80_0000);           // exact cancellation
    send_pair(32'h0080_0000, 32'h8000_0000);           // exponent falls to zero, +0
    send_pair(32'h0000_1234, 32'h0000_0001);           // first exponent zero
    send_pair(32'h7F80_0000, 32'h7FFF_FFFF);           // wrap past 255
    send_pair(32'h7FC0_0000, 32'h3F80_0000);           // NaN as normal
    send_pair(32'h3F80_0000, 32'h4B80_0000);           // difference 24
    send_pair(32'h3F80_0000, 32'h4C00_0000);           // difference 25
    send_pair(32'h0000_0000, 32'h7F80_0000);           // largest difference
    send_pair(32'h3FFF_FFFF, 32'h3F80_0000);           // carry
    send_pair(32'h3F80_0001, 32'hBF80_0000);           // deep normalisation
    send_pair(32'hC000_0000, 32'h3F80_0000);           // signs differ, larger operand negative
    send_pair(32'h4000_0000, 32'h4000_0000);           // equal exponents
    send_pair(32'h8000_0001, 32'h0000_0001);
    send_pair(32'h7FFF_FFFF, 32'hFF7F_FFFF);
    idle_sender(3);

    // Hold off until every owed result is back.
    while (sb.pending_sums.size() != 0) @(negedge clk_i);

    // Random part in bursts with random gaps.
    for (int n = 0; n < 750; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) begin
        a = $urandom;
        case ($urandom_range(0, 3))
          0: b = $urandom;
          1: b = fp(~a[31], a[30:23], a[22:0]);
          default: b = near_operand(a);
        endcase
        if ($urandom_range(0, 1)) send_pair(a, b);
        else send_pair(b, a);
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;
    stim_done  = 1'b1;
    while (sb.pending_sums.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Checked %0d sums from directed corners and random bursts,", sb.checked);
    $display("including cancellation, wrap-around and stalls on both sides.");
    if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end
endmodule

/* sim.f */
rtl/fta_pkg.sv
rtl/fta_align.sv
rtl/fta_addsub.sv
rtl/fta_norm.sv
rtl/float32_truncating_adder.sv
dv/tb_top.sv
